@@ hdl/nsf_pkg.sv @@
// Shared types, character codes and constants for the NMEA sentence framer.
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int NSF_MAX_BODY   = 80;
    localparam int NSF_ID_SLOTS   = 4;
    localparam int NSF_CFG_REGS   = 4;
    localparam int NSF_ID_W       = 40;
    localparam int NSF_CFG_W      = 41;
    localparam int NSF_CFG_IDX_W  = 3;
    localparam int NSF_BODY_CNT_W = 7;
    localparam int NSF_SLOT_W     = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic KIND_BODY = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_MARKER,
        CLS_P,
        CLS_STAR,
        CLS_COMMA,
        CLS_BLANK,
        CLS_EOL
    } cls_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TALKER,
        PH_SENT,
        PH_SEP,
        PH_BODY,
        PH_CSUM
    } phase_t;

    typedef enum logic [1:0] {
        VD_OK,
        VD_NO_CSUM,
        VD_MISMATCH,
        VD_OVERFLOW
    } verdict_t;

    typedef struct packed {
        logic [7:0] char_val;
        cls_t       cls;
        logic [3:0] nibble;
    } tok_t;

    typedef struct packed {
        logic                     we;
        logic [NSF_CFG_IDX_W-1:0] index;
        logic [NSF_CFG_W-1:0]     data;
    } cfg_wr_t;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            body_byte;
        verdict_t              verdict;
        logic [NSF_SLOT_W-1:0] id_slot;
        logic [7:0]            csum;
    } res_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            n = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            n = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            n = 4'(c - 8'h57);
        return n;
    endfunction

endpackage

@@ hdl/nsf_tok_queue.sv @@
// Two-entry queue of classified characters between front and back.
`timescale 1ns / 1ps

module nsf_tok_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  nsf_pkg::tok_t wr_tok,
    output logic          full,
    input  logic          rd_en,
    output nsf_pkg::tok_t rd_tok,
    output logic          rd_valid
);
    import nsf_pkg::*;

    tok_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_tok   = mem_reg[rptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wptr_next = do_wr ? ~wptr_reg : wptr_reg;
        rptr_next = do_rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("token queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wptr_reg != rptr_reg))
        else $error("token queue pointers disagree with count");

    a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd1) |-> (wptr_reg == rptr_reg))
        else $error("token queue pointers split while empty or full");

endmodule

@@ hdl/nsf_front.sv @@
// Front end: classify each incoming character and queue it for the framer.
`timescale 1ns / 1ps

module nsf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    byte_in,
    output logic          full,
    input  logic          tok_pop,
    output nsf_pkg::tok_t tok,
    output logic          tok_valid
);
    import nsf_pkg::*;

    tok_t in_tok;

    always_comb
    begin
        in_tok.char_val = byte_in;
        in_tok.nibble   = hex_nibble(byte_in);
        if (byte_in == CH_DOLLAR || byte_in == CH_BANG)
            in_tok.cls = CLS_MARKER;
        else if (byte_in == CH_P)
            in_tok.cls = CLS_P;
        else if (byte_in == CH_STAR)
            in_tok.cls = CLS_STAR;
        else if (byte_in == CH_COMMA)
            in_tok.cls = CLS_COMMA;
        else if (byte_in == CH_SPACE || byte_in == CH_TAB)
            in_tok.cls = CLS_BLANK;
        else if (byte_in == CH_CR || byte_in == CH_LF)
            in_tok.cls = CLS_EOL;
        else
            in_tok.cls = CLS_OTHER;
    end

    nsf_tok_queue u_tok_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_tok   (in_tok),
        .full     (full),
        .rd_en    (tok_pop),
        .rd_tok   (tok),
        .rd_valid (tok_valid)
    );

endmodule

@@ hdl/nsf_back.sv @@
// Back end: sentence state machine, ID matching, checksum and result queue.
`timescale 1ns / 1ps

module nsf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  nsf_pkg::cfg_wr_t cfg_wr,
    input  nsf_pkg::tok_t    tok,
    input  logic             tok_valid,
    output logic             tok_pop,
    output logic             empty,
    input  logic             pop,
    output nsf_pkg::res_t    res_head
);
    import nsf_pkg::*;

    logic [NSF_CFG_W-1:0]      acc_reg [NSF_CFG_REGS];

    phase_t                    phase_reg, phase_next;
    logic [NSF_ID_W-1:0]       id_chars_reg, id_chars_next;
    logic [2:0]                id_cnt_reg, id_cnt_next;
    logic [7:0]                xor_reg, xor_next;
    logic [7:0]                cap_xor_reg, cap_xor_next;
    logic [7:0]                rx_csum_reg, rx_csum_next;
    logic                      hex_cnt_reg, hex_cnt_next;
    logic [NSF_BODY_CNT_W-1:0] body_cnt_reg, body_cnt_next;
    logic [NSF_SLOT_W-1:0]     slot_reg, slot_next;

    res_t                      rq_mem_reg [2];
    logic                      rq_wptr_reg, rq_rptr_reg;
    logic [1:0]                rq_cnt_reg, rq_cnt_next;

    logic [NSF_ID_W-1:0]       id_full;
    logic                      match_hit;
    logic [NSF_SLOT_W-1:0]     match_idx;
    logic                      body_over;
    logic [7:0]                rx_full;
    logic                      res_valid;
    res_t                      res_data;
    logic                      pop_fire;

    assign pop_fire = pop && !empty;
    assign empty    = (rq_cnt_reg == 2'd0);
    assign tok_pop  = tok_valid && ((rq_cnt_reg != 2'd2) || pop_fire);
    assign res_head = rq_mem_reg[rq_rptr_reg];

    assign id_full   = {id_chars_reg[NSF_ID_W-9:0], tok.char_val};
    assign body_over = (body_cnt_reg >= NSF_BODY_CNT_W'(NSF_MAX_BODY));
    assign rx_full   = {rx_csum_reg[3:0], tok.nibble};

    // scan from the top so the lowest enabled match wins
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = NSF_ID_SLOTS - 1; i >= 0; i--)
        begin
            if (acc_reg[i][NSF_CFG_W-1] && acc_reg[i][NSF_ID_W-1:0] == id_full)
            begin
                match_hit = 1'b1;
                match_idx = NSF_SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        id_chars_next = id_chars_reg;
        id_cnt_next   = id_cnt_reg;
        xor_next      = xor_reg;
        cap_xor_next  = cap_xor_reg;
        rx_csum_next  = rx_csum_reg;
        hex_cnt_next  = hex_cnt_reg;
        body_cnt_next = body_cnt_reg;
        slot_next     = slot_reg;
        if (tok_pop)
        begin
            if (tok.cls != CLS_STAR)
                xor_next = xor_reg ^ tok.char_val;
            case (phase_reg)
                PH_TALKER:
                begin
                    if (id_cnt_reg == 3'd0 && tok.cls == CLS_P)
                        phase_next = PH_HUNT;
                    else
                    begin
                        id_chars_next = id_full;
                        id_cnt_next   = id_cnt_reg + 3'd1;
                        if (id_cnt_reg != 3'd0)
                            phase_next = PH_SENT;
                    end
                end
                PH_SENT:
                begin
                    id_chars_next = id_full;
                    id_cnt_next   = id_cnt_reg + 3'd1;
                    if (id_cnt_reg >= 3'd4)
                    begin
                        if (match_hit)
                        begin
                            slot_next  = match_idx;
                            phase_next = PH_SEP;
                        end
                        else
                            phase_next = PH_HUNT;
                    end
                end
                PH_SEP:
                begin
                    if (tok.cls == CLS_COMMA)
                    begin
                        body_cnt_next = '0;
                        phase_next    = PH_BODY;
                    end
                    else if (tok.cls != CLS_BLANK)
                        phase_next = PH_HUNT;
                end
                PH_BODY:
                begin
                    if (tok.cls == CLS_STAR)
                    begin
                        cap_xor_next = xor_reg;
                        rx_csum_next = 8'd0;
                        hex_cnt_next = 1'b0;
                        phase_next   = PH_CSUM;
                    end
                    else if (tok.cls == CLS_EOL || body_over)
                        phase_next = PH_HUNT;
                    else
                        body_cnt_next = body_cnt_reg + NSF_BODY_CNT_W'(1);
                end
                PH_CSUM:
                begin
                    rx_csum_next = rx_full;
                    hex_cnt_next = ~hex_cnt_reg;
                    if (hex_cnt_reg)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (tok.cls == CLS_MARKER)
                    begin
                        xor_next      = 8'd0;
                        id_chars_next = '0;
                        id_cnt_next   = 3'd0;
                        phase_next    = PH_TALKER;
                    end
                end
            endcase
        end
    end

    // result word
    always_comb
    begin
        res_valid          = 1'b0;
        res_data.kind      = KIND_END;
        res_data.body_byte = 8'd0;
        res_data.verdict   = VD_OK;
        res_data.id_slot   = slot_reg;
        res_data.csum      = xor_reg;
        if (tok_pop)
        begin
            case (phase_reg)
                PH_BODY:
                begin
                    if (tok.cls == CLS_EOL)
                    begin
                        res_valid        = 1'b1;
                        res_data.verdict = VD_NO_CSUM;
                    end
                    else if (tok.cls != CLS_STAR)
                    begin
                        res_valid = 1'b1;
                        if (body_over)
                            res_data.verdict = VD_OVERFLOW;
                        else
                        begin
                            res_data.kind      = KIND_BODY;
                            res_data.body_byte = tok.char_val;
                            res_data.csum      = 8'd0;
                        end
                    end
                end
                PH_CSUM:
                begin
                    res_valid        = hex_cnt_reg;
                    res_data.csum    = cap_xor_reg;
                    res_data.verdict = (rx_full == cap_xor_reg) ? VD_OK : VD_MISMATCH;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    assign rq_cnt_next = rq_cnt_reg + 2'(res_valid) - 2'(pop_fire);

    always_ff @(posedge clk)
    begin
        if (res_valid)
            rq_mem_reg[rq_wptr_reg] <= res_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSF_CFG_REGS; i++)
                acc_reg[i] <= '0;
            phase_reg    <= PH_HUNT;
            id_chars_reg <= '0;
            id_cnt_reg   <= 3'd0;
            xor_reg      <= 8'd0;
            cap_xor_reg  <= 8'd0;
            rx_csum_reg  <= 8'd0;
            hex_cnt_reg  <= 1'b0;
            body_cnt_reg <= '0;
            slot_reg     <= '0;
            rq_wptr_reg  <= 1'b0;
            rq_rptr_reg  <= 1'b0;
            rq_cnt_reg   <= 2'd0;
        end
        else
        begin
            // drop writes beyond the last register
            if (cfg_wr.we && cfg_wr.index < NSF_CFG_IDX_W'(NSF_CFG_REGS))
                acc_reg[cfg_wr.index[NSF_SLOT_W-1:0]] <= cfg_wr.data;
            phase_reg    <= phase_next;
            id_chars_reg <= id_chars_next;
            id_cnt_reg   <= id_cnt_next;
            xor_reg      <= xor_next;
            cap_xor_reg  <= cap_xor_next;
            rx_csum_reg  <= rx_csum_next;
            hex_cnt_reg  <= hex_cnt_next;
            body_cnt_reg <= body_cnt_next;
            slot_reg     <= slot_next;
            if (res_valid)
                rq_wptr_reg <= ~rq_wptr_reg;
            if (pop_fire)
                rq_rptr_reg <= ~rq_rptr_reg;
            rq_cnt_reg   <= rq_cnt_next;
        end
    end

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg <= 2'd2)
        else $error("result queue count out of range");

    a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == PH_BODY || phase_reg == PH_CSUM))
        else $error("result produced outside body or checksum");

    a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
        body_cnt_reg <= NSF_BODY_CNT_W'(NSF_MAX_BODY))
        else $error("body count ran past limit");

    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.kind == KIND_END) |=> (phase_reg == PH_HUNT))
        else $error("framer did not return to hunting after end word");

endmodule

@@ hdl/nmea_sentence_framer.sv @@
// Top level of the NMEA 0183 sentence framer.
`timescale 1ns / 1ps
//
//  channel   direction  handshake           payload
//  input     in         push / full         byte_in
//  result    out        empty / pop         result_kind, body_byte, verdict,
//                                           id_slot, computed_checksum
//  config    in         cfg_we              cfg_index, cfg_data (41 bits)
//
//  One character per cycle sustained unless the result queue stalls; a pushed
//  word goes through the classifier queue, then the framer into the result queue, before it can be popped.
//  Reset is asynchronous and clears all state, queues and ID registers.
//  A two-entry queue on each side of the framer decouples the two ports;
//  full rises only when the result side has stalled long enough to fill both.

module nmea_sentence_framer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         byte_in,
    output logic                               empty,
    input  logic                               pop,
    output logic                               result_kind,
    output logic [7:0]                         body_byte,
    output logic [1:0]                         verdict,
    output logic [1:0]                         id_slot,
    output logic [7:0]                         computed_checksum,
    input  logic                               cfg_we,
    input  logic [nsf_pkg::NSF_CFG_IDX_W-1:0]  cfg_index,
    input  logic [nsf_pkg::NSF_CFG_W-1:0]      cfg_data
);
    import nsf_pkg::*;

    tok_t    tok;
    logic    tok_valid;
    logic    tok_pop;
    cfg_wr_t cfg_wr;
    res_t    res_head;

    assign cfg_wr.we    = cfg_we;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    nsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .byte_in   (byte_in),
        .full      (full),
        .tok_pop   (tok_pop),
        .tok       (tok),
        .tok_valid (tok_valid)
    );

    nsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .tok       (tok),
        .tok_valid (tok_valid),
        .tok_pop   (tok_pop),
        .empty     (empty),
        .pop       (pop),
        .res_head  (res_head)
    );

    assign result_kind       = res_head.kind;
    assign body_byte         = res_head.body_byte;
    assign verdict           = res_head.verdict;
    assign id_slot           = res_head.id_slot;
    assign computed_checksum = res_head.csum;

endmodule
